FILE: rtl/tkcr_pkg.sv
// ----------------------------------------------------------------------------
// tkcr_pkg
// Shared widths, limits and controller/datapath handshake types for the
// top-k change ranker.
// ----------------------------------------------------------------------------
package tkcr_pkg;

    localparam int VAL_W = 16;   // Q0.16 input value
    localparam int SQ_W  = 32;   // exact square of a 16-bit difference
    localparam int SUM_W = 38;   // running sum of squares
    localparam int IDX_W = 12;   // entity number as reported
    localparam int POS_W = 4;    // rank position as reported

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ins;    // insert the finished entity sum into the top list
        logic emit;   // move the head of the top list into the output register
        logic clear;  // end of set: drop list fill, entity count and rank
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic filled_zero;  // top list holds no entry
        logic emit_last;    // the next emitted entry is the final one
        logic out_free;     // output register can take a new transfer
    } status_t;

endpackage

FILE: rtl/tkcr_ctrl.sv
// ----------------------------------------------------------------------------
// tkcr_ctrl
// Sequencer: streams dimensions, then accumulates, inserts and emits.
// ----------------------------------------------------------------------------
module tkcr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last_dim,
    input  logic              s_last_entity,
    output logic              s_ready,
    input  tkcr_pkg::status_t stat,
    output tkcr_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_ACC,
        ST_INS,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   last_ent_reg, last_ent_next;

    assign s_ready = (state_reg == ST_RUN);

    always_comb begin
        state_next    = state_reg;
        last_ent_next = last_ent_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_RUN: begin
                if (s_valid && s_last_dim) begin
                    last_ent_next = s_last_entity;
                    state_next    = ST_ACC;
                end
            end
            ST_ACC: begin
                // final square lands in the sum this cycle
                state_next = ST_INS;
            end
            ST_INS: begin
                cmd.ins    = 1'b1;
                state_next = last_ent_reg ? ST_EMIT : ST_RUN;
            end
            ST_EMIT: begin
                if (stat.filled_zero) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_RUN;
                end else if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            last_ent_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            last_ent_reg <= last_ent_next;
        end
    end

endmodule

FILE: rtl/tkcr_dp.sv
// ----------------------------------------------------------------------------
// tkcr_dp
// Square/accumulate pipeline, sorted top list and output register.
// ----------------------------------------------------------------------------
module tkcr_dp #(
    parameter int TOP_K        = 10,
    parameter int MAX_ENTITIES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [tkcr_pkg::VAL_W-1:0]    prev_value,
    input  logic [tkcr_pkg::VAL_W-1:0]    curr_value,
    input  tkcr_pkg::cmd_t                cmd,
    output tkcr_pkg::status_t             stat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tkcr_pkg::IDX_W-1:0]    m_entity_number,
    output logic [tkcr_pkg::POS_W-1:0]    m_rank_pos,
    output logic [tkcr_pkg::SUM_W-1:0]    m_distance_sq,
    output logic                          m_last
);

    localparam int CW    = $clog2(MAX_ENTITIES + 1);
    localparam int FW    = $clog2(TOP_K + 1);
    localparam int VAL_W = tkcr_pkg::VAL_W;
    localparam int SQ_W  = tkcr_pkg::SQ_W;
    localparam int SUM_W = tkcr_pkg::SUM_W;
    localparam int IDX_W = tkcr_pkg::IDX_W;
    localparam int POS_W = tkcr_pkg::POS_W;

    // square stage
    logic [VAL_W-1:0] diff;
    logic [SQ_W-1:0]  sq_reg;
    logic             sqv_reg;

    // accumulator
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W:0]   sum_wide;

    // top list
    logic [SUM_W-1:0] dist_reg [TOP_K];
    logic [IDX_W-1:0] idx_reg  [TOP_K];
    logic [SUM_W-1:0] dist_ins [TOP_K];
    logic [IDX_W-1:0] idx_ins  [TOP_K];
    logic [SUM_W-1:0] prev_dist [TOP_K];
    logic [IDX_W-1:0] prev_idx  [TOP_K];
    logic [TOP_K-1:0] greater;
    logic [TOP_K-1:0] above;
    logic [FW-1:0]    filled_reg;
    logic [FW-1:0]    rank_reg;
    logic [CW-1:0]    count_reg;
    logic [IDX_W-1:0] new_idx;
    logic [CW+IDX_W-1:0] count_ext;
    logic [FW+POS_W-1:0] rank_ext;
    logic             room;
    logic             do_ins;
    logic             m_valid_reg;

    assign diff = (curr_value >= prev_value) ? (curr_value - prev_value)
                                             : (prev_value - curr_value);

    always_ff @(posedge aclk) begin
        sq_reg <= SQ_W'(diff) * SQ_W'(diff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqv_reg <= 1'b0;
        end else begin
            sqv_reg <= accept;
        end
    end

    // saturating accumulate
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);

    always_comb begin
        sum_next = sum_reg;
        if (sqv_reg) begin
            sum_next = sum_wide[SUM_W] ? tkcr_pkg::SUM_MAX : sum_wide[SUM_W-1:0];
        end else if (cmd.ins || cmd.clear) begin
            sum_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    // parallel insertion: an entry stays where it is while it beats the new sum
    assign count_ext = {{IDX_W{1'b0}}, count_reg};
    assign new_idx   = count_ext[IDX_W-1:0];
    assign room      = (count_reg < CW'(MAX_ENTITIES));

    always_comb begin
        for (int i = 0; i < TOP_K; i++) begin
            greater[i] = (FW'(i) < filled_reg) && (dist_reg[i] > sum_reg);
        end
    end

    for (genvar gi = 0; gi < TOP_K; gi++) begin : g_slot
        if (gi == 0) begin : g_head
            assign above[gi]     = 1'b1;
            assign prev_dist[gi] = sum_reg;
            assign prev_idx[gi]  = new_idx;
        end else begin : g_body
            assign above[gi]     = greater[gi-1];
            assign prev_dist[gi] = dist_reg[gi-1];
            assign prev_idx[gi]  = idx_reg[gi-1];
        end
        always_comb begin
            if (greater[gi]) begin
                dist_ins[gi] = dist_reg[gi];
                idx_ins[gi]  = idx_reg[gi];
            end else if (above[gi]) begin
                dist_ins[gi] = sum_reg;
                idx_ins[gi]  = new_idx;
            end else begin
                dist_ins[gi] = prev_dist[gi];
                idx_ins[gi]  = prev_idx[gi];
            end
        end
    end

    assign do_ins = cmd.ins && room && !greater[TOP_K-1];

    // list storage: insert, or shift toward the head while emitting
    always_ff @(posedge aclk) begin
        if (do_ins) begin
            for (int i = 0; i < TOP_K; i++) begin
                dist_reg[i] <= dist_ins[i];
                idx_reg[i]  <= idx_ins[i];
            end
        end else if (cmd.emit) begin
            for (int i = 0; i < TOP_K - 1; i++) begin
                dist_reg[i] <= dist_reg[i+1];
                idx_reg[i]  <= idx_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= '0;
            count_reg  <= '0;
            rank_reg   <= '0;
        end else if (cmd.clear) begin
            filled_reg <= '0;
            count_reg  <= '0;
            rank_reg   <= '0;
        end else begin
            if (do_ins && (filled_reg < FW'(TOP_K))) begin
                filled_reg <= filled_reg + FW'(1);
            end
            if (cmd.ins && room) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.emit) begin
                rank_reg <= rank_reg + FW'(1);
            end
        end
    end

    // output register
    assign rank_ext = {{POS_W{1'b0}}, rank_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_entity_number <= idx_reg[0];
            m_rank_pos      <= rank_ext[POS_W-1:0];
            m_distance_sq   <= dist_reg[0];
            m_last          <= stat.emit_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign stat.filled_zero = (filled_reg == '0);
    assign stat.emit_last   = ((rank_reg + FW'(1)) == filled_reg);
    assign stat.out_free    = !m_valid_reg || m_ready;

endmodule

FILE: rtl/top_k_change_ranker.sv
// ----------------------------------------------------------------------------
// top_k_change_ranker
// Ranks entities by squared Euclidean change and reports the TOP_K largest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one transfer per dimension of an entity, carrying the
//   earlier and current Q0.16 values. s_last_dim closes an entity; together
//   with s_last_entity it closes the set. Entities are numbered by arrival.
//   Result channel (m_*): after a set closes, the kept entries go out from the
//   largest distance to the smallest, rank_pos counting from 0, m_last on the
//   final one. Ties rank the later entity higher.
//   Rate: while s_ready is high, a dimension that does not close an entity is
//   taken every clock; the registered 16x16 squarer feeds the accumulator.
//   A closing dimension passes through accept, final accumulate, and parallel
//   compare-and-insert into the sorted list. Closing a set then sends each
//   kept result through the single output register, a new one whenever that
//   register is free.
//   Stall: a held result sits in the output register; emission waits on
//   m_ready and input is not taken until the list has drained into it.
//   Reset: synchronous, active low; clears the sum, entity count, list fill
//   and both channels' valid state. List contents need no reset.
// ----------------------------------------------------------------------------
module top_k_change_ranker #(
    parameter int TOP_K        = 10,
    parameter int MAX_ENTITIES = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [tkcr_pkg::VAL_W-1:0] s_prev_value,
    input  logic [tkcr_pkg::VAL_W-1:0] s_curr_value,
    input  logic                       s_last_dim,
    input  logic                       s_last_entity,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [tkcr_pkg::IDX_W-1:0] m_entity_number,
    output logic [tkcr_pkg::POS_W-1:0] m_rank_pos,
    output logic [tkcr_pkg::SUM_W-1:0] m_distance_sq,
    output logic                       m_last
);

    tkcr_pkg::cmd_t    cmd;
    tkcr_pkg::status_t stat;
    logic              accept;

    // an input transfer completes on valid and ready together
    assign accept = s_valid && s_ready;

    // sequencer: streams dimensions, then walks insert and emission
    tkcr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_last_dim    (s_last_dim),
        .s_last_entity (s_last_entity),
        .s_ready       (s_ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // squarer, accumulator, sorted list and output register
    tkcr_dp #(
        .TOP_K        (TOP_K),
        .MAX_ENTITIES (MAX_ENTITIES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .prev_value      (s_prev_value),
        .curr_value      (s_curr_value),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_entity_number (m_entity_number),
        .m_rank_pos      (m_rank_pos),
        .m_distance_sq   (m_distance_sq),
        .m_last          (m_last)
    );

endmodule
